[hw/rtl/b32enc_pkg.sv]
// Shared constants, types and the character table of the Bech32 string encoder.
package b32enc_pkg;

  localparam int unsigned MAX_LEN    = 90;
  localparam int unsigned CSUM_CHARS = 6;
  localparam int unsigned PFX_MAX    = MAX_LEN - 1 - CSUM_CHARS;
  // counts and lengths reach PFX_MAX + 1
  localparam int unsigned CNT_W      = $clog2(PFX_MAX + 2);
  localparam int unsigned ADDR_W     = $clog2(PFX_MAX);
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned SYM_W      = 5;

  localparam logic [CHAR_W-1:0] SEP_CHAR = 7'h31;

  typedef enum logic [1:0] {
    CS_HOLD,
    CS_INIT,
    CS_STEP,
    CS_SHIFT
  } csum_op_e;

  typedef struct packed {
    csum_op_e         op;
    logic [SYM_W-1:0] sym;
  } csum_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
    logic              err;
  } out_item_t;

  function automatic logic [CHAR_W-1:0] alphabet(input logic [SYM_W-1:0] g);
    logic [CHAR_W-1:0] c;
    unique case (g)
      5'd0:  c = 7'h71;  // q
      5'd1:  c = 7'h70;  // p
      5'd2:  c = 7'h7a;  // z
      5'd3:  c = 7'h72;  // r
      5'd4:  c = 7'h79;  // y
      5'd5:  c = 7'h39;  // 9
      5'd6:  c = 7'h78;  // x
      5'd7:  c = 7'h38;  // 8
      5'd8:  c = 7'h67;  // g
      5'd9:  c = 7'h66;  // f
      5'd10: c = 7'h32;  // 2
      5'd11: c = 7'h74;  // t
      5'd12: c = 7'h76;  // v
      5'd13: c = 7'h64;  // d
      5'd14: c = 7'h77;  // w
      5'd15: c = 7'h30;  // 0
      5'd16: c = 7'h73;  // s
      5'd17: c = 7'h33;  // 3
      5'd18: c = 7'h6a;  // j
      5'd19: c = 7'h6e;  // n
      5'd20: c = 7'h35;  // 5
      5'd21: c = 7'h34;  // 4
      5'd22: c = 7'h6b;  // k
      5'd23: c = 7'h68;  // h
      5'd24: c = 7'h63;  // c
      5'd25: c = 7'h65;  // e
      5'd26: c = 7'h36;  // 6
      5'd27: c = 7'h6d;  // m
      5'd28: c = 7'h75;  // u
      5'd29: c = 7'h61;  // a
      5'd30: c = 7'h37;  // 7
      5'd31: c = 7'h6c;  // l
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/b32enc_polymod.sv]
// Checksum register with the shared BCH step / symbol shift unit.
module b32enc_polymod import b32enc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csum_cmd_t        cmd_i,
  output logic [SYM_W-1:0] top_o
);

  localparam logic [29:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  logic [29:0] csum_q, csum_d;
  logic [29:0] mixed;
  logic [29:0] shifted;

  always_comb begin
    shifted = {csum_q[24:0], 5'b0};
    mixed   = shifted ^ {25'b0, cmd_i.sym};
    for (int i = 0; i < 5; i++) begin
      if (csum_q[25+i]) mixed = mixed ^ GEN[i];
    end
    unique case (cmd_i.op)
      CS_HOLD:  csum_d = csum_q;
      CS_INIT:  csum_d = 30'd1;
      CS_STEP:  csum_d = mixed;
      CS_SHIFT: csum_d = shifted;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= 30'd1;
    end else begin
      csum_q <= csum_d;
    end
  end

  assign top_o = csum_q[29:25];

endmodule

[hw/rtl/b32enc_out_buf.sv]
// Output register of the encoder: case conversion and the master-side stream.
module b32enc_out_buf import b32enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       upper_i,
  input  logic       push_i,
  input  out_item_t  item_i,
  output logic       room_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast,   // last
  output logic       m_axis_tuser    // error
);

  logic              valid_q, valid_d;
  out_item_t         item_q;
  logic [CHAR_W-1:0] chr_cased;

  assign room_o = !valid_q || m_axis_tready;

  always_comb begin
    chr_cased = item_i.chr;
    if (upper_i && (item_i.chr >= 7'h61) && (item_i.chr <= 7'h7a)) begin
      chr_cased = item_i.chr ^ 7'h20;
    end
  end

  assign valid_d = push_i || (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= '{chr: chr_cased, last: item_i.last, err: item_i.err};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, item_q.chr};
  assign m_axis_tlast  = item_q.last;
  assign m_axis_tuser  = item_q.err;

endmodule

[hw/rtl/bech32_string_encoder_core.sv]
// Bech32 string encoder: sequencer, prefix store and output around one checksum unit.
//
//  channel  | direction | tdata                | tuser                        | tlast
//  s_axis   | in        | data_byte            | [0] mode, [1] end_of_prefix  | end_of_message
//  m_axis   | out       | [6:0] out_char       | error                        | last
//  cfg      | in        | uppercase_output     | -                            | -
//
// Closing the prefix replays every stored prefix byte into the checksum; the message end
// adds a zero-padded group when bits are left over, then 6 checksum steps and 6 output
// characters.
// Reset is asynchronous and clears control state; the prefix store is not cleared.
// A stalled output holds the sequencer in place; s_axis_tready is high only when idle.
module bech32_string_encoder_core import b32enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,    // uppercase_output
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic [1:0] s_axis_tuser,   // [0] mode, [1] end_of_prefix
  input  logic       s_axis_tlast,   // end_of_message
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast,   // last
  output logic       m_axis_tuser    // error
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PFX      = 4'd1;
  localparam logic [3:0] ST_PFX_EMIT = 4'd2;
  localparam logic [3:0] ST_CLOSE    = 4'd3;
  localparam logic [3:0] ST_SEP      = 4'd4;
  localparam logic [3:0] ST_REPLAY   = 4'd5;
  localparam logic [3:0] ST_GRP      = 4'd6;
  localparam logic [3:0] ST_FIN      = 4'd7;
  localparam logic [3:0] ST_FIN_CHK  = 4'd8;
  localparam logic [3:0] ST_TAIL_MIX = 4'd9;
  localparam logic [3:0] ST_TAIL_OUT = 4'd10;
  localparam logic [3:0] ST_ERR      = 4'd11;

  logic [3:0]       state_q, state_d;
  logic             upper_q;
  logic             mode_q, eop_q, eom_q;
  logic [7:0]       byte_q;
  logic             closed_q, closed_d;
  logic             fault_q, fault_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [2:0]       lc_q, lc_d;
  logic [3:0]       left_q, left_d;
  logic [11:0]      acc_q, acc_d;
  logic [3:0]       bits_q, bits_d;
  logic             fin_q, fin_d;
  logic [2:0]       k_q, k_d;

  logic [SYM_W-1:0] mem [PFX_MAX];
  logic [SYM_W-1:0] rdata_q;
  logic             mem_we;

  logic             in_fire;
  logic             clear;
  csum_cmd_t        cmd;
  logic [SYM_W-1:0] cs_top;
  logic             push;
  out_item_t        item;
  logic             room;
  logic [3:0]       after_pfx;
  logic [3:0]       route_close;
  logic [4:0]       grp_sh;
  logic [3:0]       lo_mask;
  logic [4:0]       pad;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign after_pfx   = (eop_q && !eom_q) ? ST_CLOSE : (eom_q ? ST_FIN : ST_IDLE);
  assign route_close = mode_q ? ST_GRP : (eom_q ? ST_FIN : ST_IDLE);
  assign grp_sh      = 5'(acc_q >> (bits_q - 4'd5));
  assign lo_mask     = (4'd1 << bits_q) - 4'd1;
  assign pad         = {1'b0, left_q} << (3'd5 - lc_q);

  always_comb begin
    state_d  = state_q;
    closed_d = closed_q;
    fault_d  = fault_q;
    count_d  = count_q;
    total_d  = total_q;
    idx_d    = idx_q;
    lc_d     = lc_q;
    left_d   = left_q;
    acc_d    = acc_q;
    bits_d   = bits_q;
    fin_d    = fin_q;
    k_d      = k_q;
    mem_we   = 1'b0;
    clear    = 1'b0;
    push     = 1'b0;
    item     = '{chr: '0, last: 1'b0, err: 1'b0};
    cmd      = '{op: CS_HOLD, sym: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          acc_d  = {left_q, s_axis_tdata};
          bits_d = {1'b0, lc_q} + 4'd8;
          fin_d  = 1'b0;
          if (!s_axis_tuser[0]) begin
            state_d = ST_PFX;
          end else if (closed_q) begin
            state_d = ST_GRP;
          end else begin
            state_d = ST_CLOSE;
          end
        end
      end

      ST_PFX: begin
        if (closed_q) begin
          fault_d = 1'b1;
          state_d = eom_q ? ST_FIN : ST_IDLE;
        end else begin
          if (count_q <= CNT_W'(PFX_MAX)) count_d = count_q + 1'b1;
          if (count_q >= CNT_W'(PFX_MAX)) begin
            fault_d = 1'b1;
            state_d = after_pfx;
          end else begin
            mem_we  = 1'b1;
            cmd     = '{op: CS_STEP, sym: {2'b0, byte_q[7:5]}};
            state_d = fault_q ? after_pfx : ST_PFX_EMIT;
          end
        end
      end

      ST_PFX_EMIT: begin
        if (room) begin
          push    = 1'b1;
          item    = '{chr: byte_q[6:0], last: 1'b0, err: 1'b0};
          state_d = after_pfx;
        end
      end

      ST_CLOSE: begin
        closed_d = 1'b1;
        if (fault_q || (count_q == '0)) begin
          fault_d = 1'b1;
          state_d = route_close;
        end else begin
          cmd     = '{op: CS_STEP, sym: '0};
          total_d = count_q + 1'b1;
          idx_d   = '0;
          state_d = ST_SEP;
        end
      end

      ST_SEP: begin
        if (room) begin
          push    = 1'b1;
          item    = '{chr: SEP_CHAR, last: 1'b0, err: 1'b0};
          state_d = ST_REPLAY;
        end
      end

      // rdata_q holds the entry at idx_q (read address follows idx_d)
      ST_REPLAY: begin
        if (idx_q < count_q) begin
          cmd   = '{op: CS_STEP, sym: rdata_q};
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = route_close;
        end
      end

      ST_GRP: begin
        if (bits_q >= 4'd5) begin
          if (fault_q) begin
            bits_d = bits_q - 4'd5;
          end else if (total_q > CNT_W'(PFX_MAX)) begin
            // string plus checksum would exceed the length limit
            fault_d = 1'b1;
            bits_d  = bits_q - 4'd5;
          end else if (room) begin
            push    = 1'b1;
            item    = '{chr: alphabet(grp_sh[4:0]), last: 1'b0, err: 1'b0};
            cmd     = '{op: CS_STEP, sym: grp_sh[4:0]};
            total_d = total_q + 1'b1;
            bits_d  = bits_q - 4'd5;
          end
        end else begin
          lc_d   = bits_q[2:0];
          left_d = acc_q[3:0] & lo_mask[3:0];
          if (fin_q) begin
            state_d = ST_FIN_CHK;
          end else begin
            state_d = eom_q ? ST_FIN : ST_IDLE;
          end
        end
      end

      ST_FIN: begin
        if (!closed_q) begin
          state_d = ST_CLOSE;
        end else if (lc_q != 3'd0) begin
          // zero-padded trailing group
          acc_d   = {7'b0, pad[4:0]};
          bits_d  = 4'd5;
          fin_d   = 1'b1;
          state_d = ST_GRP;
        end else begin
          state_d = ST_FIN_CHK;
        end
      end

      ST_FIN_CHK: begin
        k_d = '0;
        if (fault_q || (count_q == '0)) begin
          state_d = ST_ERR;
        end else begin
          state_d = ST_TAIL_MIX;
        end
      end

      // six zero steps; the final xor with 1 is folded into the last step
      ST_TAIL_MIX: begin
        cmd = '{op: CS_STEP, sym: (k_q == 3'd5) ? 5'd1 : 5'd0};
        if (k_q == 3'd5) begin
          k_d     = '0;
          state_d = ST_TAIL_OUT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_TAIL_OUT: begin
        if (room) begin
          push = 1'b1;
          item = '{chr: alphabet(cs_top), last: (k_q == 3'd5), err: 1'b0};
          if (k_q == 3'd5) begin
            cmd     = '{op: CS_INIT, sym: '0};
            clear   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cmd = '{op: CS_SHIFT, sym: '0};
            k_d = k_q + 1'b1;
          end
        end
      end

      ST_ERR: begin
        if (room) begin
          push    = 1'b1;
          item    = '{chr: '0, last: 1'b1, err: 1'b1};
          cmd     = '{op: CS_INIT, sym: '0};
          clear   = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (clear) begin
      closed_d = 1'b0;
      fault_d  = 1'b0;
      count_d  = '0;
      total_d  = '0;
      lc_d     = '0;
      left_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      upper_q  <= 1'b0;
      closed_q <= 1'b0;
      fault_q  <= 1'b0;
      count_q  <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      lc_q     <= '0;
      left_q   <= '0;
      bits_q   <= '0;
      fin_q    <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) upper_q <= cfg_wdata_i;
      closed_q <= closed_d;
      fault_q  <= fault_d;
      count_q  <= count_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      lc_q     <= lc_d;
      left_q   <= left_d;
      bits_q   <= bits_d;
      fin_q    <= fin_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= s_axis_tuser[0];
      eop_q  <= s_axis_tuser[1];
      eom_q  <= s_axis_tlast;
      byte_q <= s_axis_tdata;
    end
    acc_q <= acc_d;
  end

  // prefix low-bit store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[ADDR_W-1:0]] <= byte_q[4:0];
    end
    rdata_q <= mem[idx_d[ADDR_W-1:0]];
  end

  b32enc_polymod u_polymod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .top_o  (cs_top)
  );

  b32enc_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upper_i       (upper_q),
    .push_i        (push),
    .item_i        (item),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> room)
    else $error("result pushed into a full output register");

  a_replay_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPLAY) |-> (idx_q <= count_q))
    else $error("prefix replay ran past the stored count");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'h00)))
    else $error("error result is not a final empty transfer");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q <= CNT_W'(PFX_MAX + 1)) && (count_q <= CNT_W'(PFX_MAX + 1)))
    else $error("length counters out of range");
`endif

endmodule
